/* hw/rtl/wva_pkg.sv */
// wind vector averager: shared types, field widths and vane lookup tables
package wva_pkg;

	localparam int TIME_W  = 32;
	localparam int ADC_W   = 10;
	localparam int VEC_W   = 11;
	localparam int SPEED_W = 32;
	localparam int SLOT_W  = 5;
	localparam int DEB_W   = 8;
	localparam int SCALE_W = 16;
	localparam int CNT_W   = 16;
	localparam int CFG_W   = 16;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 64;
	localparam int VANE_POINTS = 16;

	localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 8'd10;
	localparam logic [SCALE_W-1:0] SCALE_RST    = 16'd1492;

	typedef enum logic {
		CMD_PULSE = 1'b0,
		CMD_TICK  = 1'b1
	} wva_cmd_t;

	typedef enum logic {
		REG_DEBOUNCE    = 1'b0,
		REG_SPEED_SCALE = 1'b1
	} wva_reg_t;

	// ascending thresholds, a sample below limit takes that vector
	localparam logic [ADC_W-1:0] VANE_LIMIT [VANE_POINTS] = '{
		10'd380, 10'd393, 10'd414, 10'd456, 10'd508, 10'd551, 10'd615, 10'd680,
		10'd746, 10'd801, 10'd833, 10'd878, 10'd913, 10'd940, 10'd967, 10'd990
	};

	localparam logic signed [VEC_W-1:0] VANE_X [VANE_POINTS] = '{
		-11'sd924, -11'sd924, -11'sd1000, -11'sd383, -11'sd707, 11'sd382, 11'sd0, -11'sd383,
		-11'sd707, 11'sd924, 11'sd707, 11'sd383, 11'sd0, 11'sd924, 11'sd707, 11'sd1000
	};

	localparam logic signed [VEC_W-1:0] VANE_Y [VANE_POINTS] = '{
		-11'sd383, 11'sd383, 11'sd0, -11'sd924, -11'sd707, -11'sd924, -11'sd1000, 11'sd924,
		11'sd707, -11'sd383, -11'sd707, 11'sd924, 11'sd1000, 11'sd383, 11'sd707, 11'sd0
	};

endpackage

/* hw/rtl/wva_div.sv */
// wind vector averager: window mean by reciprocal multiply, two stages, the second ending in the output register
module wva_div #(
	parameter int WINDOW_SECONDS = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [$clog2(1000*WINDOW_SECONDS+1):0] sum_x,
	input  logic signed [$clog2(1000*WINDOW_SECONDS+1):0] sum_y,
	input  logic [32+$clog2(WINDOW_SECONDS)-1:0] sum_speed,
	input  logic [wva_pkg::SLOT_W-1:0] slot_in,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [wva_pkg::VEC_W-1:0] avg_x,
	output logic signed [wva_pkg::VEC_W-1:0] avg_y,
	output logic [wva_pkg::SPEED_W-1:0] avg_speed,
	output logic [wva_pkg::SLOT_W-1:0] slot_out
);
	import wva_pkg::*;

	localparam int L        = $clog2(WINDOW_SECONDS);
	localparam int XY_N     = $clog2(1000*WINDOW_SECONDS+1);
	localparam int XY_SUM_W = XY_N + 1;
	localparam int XY_K     = XY_N + L;
	localparam int XY_P_W   = 2*XY_N + 1;
	localparam longint unsigned XY_M =
		((64'd1 << XY_K) + 64'(WINDOW_SECONDS) - 64'd1) / 64'(WINDOW_SECONDS);
	localparam int SPD_SUM_W = 32 + L;
	localparam int DN        = 16 + L;
	localparam int SP_K      = DN + L;
	localparam int SP_P_W    = 2*DN + 1;
	localparam longint unsigned SP_M =
		((64'd1 << SP_K) + 64'(WINDOW_SECONDS) - 64'd1) / 64'(WINDOW_SECONDS);
	localparam int HALF_W = 16;

	logic                   v_s3;
	logic                   neg_x_s3, neg_y_s3;
	logic [VEC_W-1:0]       qx_s3, qy_s3;
	logic [HALF_W-1:0]      qh_s3;
	logic [DN-1:0]          nhi_s3;
	logic [HALF_W-1:0]      nlo_s3;
	logic [SLOT_W-1:0]      slot_s3;

	logic                   out_valid_q;
	logic signed [VEC_W-1:0] avg_x_q, avg_y_q;
	logic [HALF_W-1:0]      spd_hi_q, spd_lo_q;
	logic [SLOT_W-1:0]      slot_q;

	logic                   rdy_out, rdy_s3;
	logic [XY_SUM_W-1:0]    abs_x, abs_y;
	logic [XY_P_W-1:0]      prod_x, prod_y;
	logic [SP_P_W-1:0]      prod_hi, prod_lo;
	logic [DN-1:0]          n_hi, rem, t_lo;
	logic [VEC_W-1:0]       fx, fy;

	assign rdy_out  = !out_valid_q || out_ready;
	assign rdy_s3   = !v_s3 || rdy_out;
	assign in_ready = rdy_s3;

	// first stage: magnitudes and upper quotient half
	always_comb begin
		abs_x   = sum_x[XY_SUM_W-1] ? XY_SUM_W'(-sum_x) : XY_SUM_W'(sum_x);
		abs_y   = sum_y[XY_SUM_W-1] ? XY_SUM_W'(-sum_y) : XY_SUM_W'(sum_y);
		prod_x  = XY_P_W'(abs_x[XY_N-1:0]) * XY_P_W'(XY_M);
		prod_y  = XY_P_W'(abs_y[XY_N-1:0]) * XY_P_W'(XY_M);
		n_hi    = sum_speed[SPD_SUM_W-1:HALF_W];
		prod_hi = SP_P_W'(n_hi) * SP_P_W'(SP_M);
	end

	// second stage: remainder folds into the lower half
	always_comb begin
		rem     = nhi_s3 - DN'(DN'(qh_s3) * DN'(WINDOW_SECONDS));
		t_lo    = (rem << HALF_W) | DN'(nlo_s3);
		prod_lo = SP_P_W'(t_lo) * SP_P_W'(SP_M);
		fx      = neg_x_s3 ? VEC_W'(-qx_s3) : qx_s3;
		fy      = neg_y_s3 ? VEC_W'(-qy_s3) : qy_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s3)
				v_s3 <= in_valid;
			if (rdy_out)
				out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			neg_x_s3 <= sum_x[XY_SUM_W-1];
			neg_y_s3 <= sum_y[XY_SUM_W-1];
			qx_s3    <= prod_x[XY_K +: VEC_W];
			qy_s3    <= prod_y[XY_K +: VEC_W];
			qh_s3    <= prod_hi[SP_K +: HALF_W];
			nhi_s3   <= n_hi;
			nlo_s3   <= sum_speed[HALF_W-1:0];
			slot_s3  <= slot_in;
		end
		if (rdy_out && v_s3) begin
			avg_x_q  <= fx;
			avg_y_q  <= fy;
			spd_hi_q <= qh_s3;
			spd_lo_q <= prod_lo[SP_K +: HALF_W];
			slot_q   <= slot_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign avg_x     = avg_x_q;
	assign avg_y     = avg_y_q;
	assign avg_speed = {spd_hi_q, spd_lo_q};
	assign slot_out  = slot_q;

endmodule

/* hw/rtl/wind_vector_averager.sv */
// wind vector averager: top level with pulse debounce, vane lookup and window sums
// One transaction is accepted per clock while s_tready is high. A pulse event (tuser 0) updates the debounced
// pulse count and gives no output. A tick (tuser 1) maps the vane sample to a unit vector,
// turns the pulse count into a speed with one 16x16 multiply and clears the count; every
// WINDOW_SECONDS ticks the means of x, y and speed appear on the master side after the closing
// tick is accepted: the accepting edge loads the vector and product stage, then come the window
// sums and two reciprocal-multiply stages for the division by WINDOW_SECONDS, the last of them
// being the output register. The slave side stays ready while a finished mean waits; it stalls
// only when a closing tick finds the whole path behind it full.
// Output tdata, from bit 0: avg_x[10:0], avg_y[21:11], avg_speed[53:22],
// history_slot[58:54], zero fill. Registers: index 0 debounce_ms, index 1 speed_scale.
module wind_vector_averager #(
	parameter int WINDOW_SECONDS = 5,
	parameter int HISTORY_SLOTS  = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [wva_pkg::IN_DATA_W-1:0] s_tdata,   // time_ms[31:0], vane_adc[41:32], zero fill
	input  logic [0:0] s_tuser,                      // command
	output logic m_tvalid,
	input  logic m_tready,
	output logic [wva_pkg::OUT_DATA_W-1:0] m_tdata,  // avg_x, avg_y, avg_speed, history_slot
	input  logic cfg_valid,
	output logic cfg_ready,
	input  wva_pkg::wva_reg_t cfg_index,
	input  logic [wva_pkg::CFG_W-1:0] cfg_data
);
	import wva_pkg::*;

	localparam int WIN_W     = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;
	localparam int XY_SUM_W  = $clog2(1000*WINDOW_SECONDS+1) + 1;
	localparam int SPD_SUM_W = 32 + $clog2(WINDOW_SECONDS);
	localparam int PAD_W     = OUT_DATA_W - 2*VEC_W - SPEED_W - SLOT_W;

	logic [DEB_W-1:0]   debounce_q;
	logic [SCALE_W-1:0] speed_scale_q;
	logic [TIME_W-1:0]  last_pulse_q;
	logic [CNT_W-1:0]   pulse_count_q;
	logic [WIN_W-1:0]   win_q;
	logic [SLOT_W-1:0]  slot_q;
	logic signed [XY_SUM_W-1:0] sum_x_q, sum_y_q;
	logic [SPD_SUM_W-1:0] sum_spd_q;

	logic                    v_s1, close_s1;
	logic signed [VEC_W-1:0] x_s1, y_s1;
	logic [SPEED_W-1:0]      speed_s1;
	logic [SLOT_W-1:0]       slot_s1;

	logic                       v_s2;
	logic signed [XY_SUM_W-1:0] sum_x_s2, sum_y_s2;
	logic [SPD_SUM_W-1:0]       sum_spd_s2;
	logic [SLOT_W-1:0]          slot_s2;

	logic                    acc, is_tick, count_pulse, closing;
	logic                    rdy_s1, rdy_s2, div_ready;
	logic [TIME_W-1:0]       time_in, elapsed;
	logic [ADC_W-1:0]        adc_in;
	logic signed [VEC_W-1:0] vec_x, vec_y;
	logic [SPEED_W-1:0]      speed_prod;
	logic signed [XY_SUM_W-1:0] sx_next, sy_next;
	logic [SPD_SUM_W-1:0]    sspd_next;

	logic signed [VEC_W-1:0] avg_x, avg_y;
	logic [SPEED_W-1:0]      avg_speed;
	logic [SLOT_W-1:0]       slot_out;

	assign time_in     = s_tdata[TIME_W-1:0];
	assign adc_in      = s_tdata[TIME_W +: ADC_W];
	assign is_tick     = wva_cmd_t'(s_tuser[0]) == CMD_TICK;
	assign acc         = s_tvalid && s_tready;
	assign elapsed     = time_in - last_pulse_q;
	assign count_pulse = elapsed > TIME_W'(debounce_q);
	assign closing     = win_q == WIN_W'(WINDOW_SECONDS - 1);
	assign speed_prod  = SPEED_W'(pulse_count_q) * SPEED_W'(speed_scale_q);

	assign rdy_s2   = !v_s2 || div_ready;
	assign rdy_s1   = !v_s1 || !close_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign cfg_ready = 1'b1;

	always_comb begin
		vec_x = '0;
		vec_y = '0;
		for (int i = VANE_POINTS - 1; i >= 0; i--) begin
			if (adc_in < VANE_LIMIT[i]) begin
				vec_x = VANE_X[i];
				vec_y = VANE_Y[i];
			end
		end
	end

	assign sx_next   = sum_x_q + XY_SUM_W'(x_s1);
	assign sy_next   = sum_y_q + XY_SUM_W'(y_s1);
	assign sspd_next = sum_spd_q + SPD_SUM_W'(speed_s1);

	// configuration and per-item state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= DEBOUNCE_RST;
			speed_scale_q <= SCALE_RST;
			last_pulse_q  <= '0;
			pulse_count_q <= '0;
			win_q         <= '0;
			slot_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEBOUNCE:    debounce_q    <= cfg_data[DEB_W-1:0];
					REG_SPEED_SCALE: speed_scale_q <= cfg_data[SCALE_W-1:0];
					default: ;
				endcase
			end
			if (acc) begin
				if (!is_tick) begin
					if (count_pulse) begin
						last_pulse_q <= time_in;
						if (pulse_count_q != '1)
							pulse_count_q <= pulse_count_q + CNT_W'(1);
					end
				end else begin
					pulse_count_q <= '0;
					win_q <= closing ? '0 : win_q + WIN_W'(1);
					if (closing)
						slot_q <= (slot_q == SLOT_W'(HISTORY_SLOTS - 1)) ? '0
							: slot_q + SLOT_W'(1);
				end
			end
		end
	end

	// window sums and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			sum_spd_q <= '0;
		end else begin
			if (rdy_s1)
				v_s1 <= acc && is_tick;
			if (rdy_s2)
				v_s2 <= v_s1 && close_s1;
			if (v_s1 && rdy_s1) begin
				if (close_s1) begin
					sum_x_q   <= '0;
					sum_y_q   <= '0;
					sum_spd_q <= '0;
				end else begin
					sum_x_q   <= sx_next;
					sum_y_q   <= sy_next;
					sum_spd_q <= sspd_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_tick) begin
			close_s1 <= closing;
			x_s1     <= vec_x;
			y_s1     <= vec_y;
			speed_s1 <= speed_prod;
			slot_s1  <= slot_q;
		end
		if (rdy_s2 && v_s1 && close_s1) begin
			sum_x_s2   <= sx_next;
			sum_y_s2   <= sy_next;
			sum_spd_s2 <= sspd_next;
			slot_s2    <= slot_s1;
		end
	end

	wva_div #(
		.WINDOW_SECONDS(WINDOW_SECONDS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_ready),
		.sum_x     (sum_x_s2),
		.sum_y     (sum_y_s2),
		.sum_speed (sum_spd_s2),
		.slot_in   (slot_s2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.avg_x     (avg_x),
		.avg_y     (avg_y),
		.avg_speed (avg_speed),
		.slot_out  (slot_out)
	);

	assign m_tdata = {PAD_W'(0), slot_out, avg_speed, avg_y, avg_x};

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, m_tdata[OUT_DATA_W-PAD_W-1 -: SLOT_W]}
			< (SLOT_W+1)'(HISTORY_SLOTS)))
		else $error("history slot out of range");

	a_sums_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && close_s1 && rdy_s1) |=> (sum_x_q == '0 && sum_y_q == '0 && sum_spd_q == '0))
		else $error("window sums not cleared after closing tick");

	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_tick) |=> (pulse_count_q == '0))
		else $error("pulse count not cleared by tick");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !div_ready) |=> (v_s2 && $stable(slot_s2)))
		else $error("window result lost while divider stalled");

endmodule

/* verif/testbench.sv */
// self-checking testbench for the wind vector averager: directed table, then random pulse and tick traffic
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import wva_pkg::*;

	localparam int WINDOW       = 5;
	localparam int SLOTS        = 24;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 250;
	localparam int CYCLE_LIMIT  = 600000;

	// compass points: upper adc limit, x, y
	localparam int COMPASS [16][3] = '{
		'{380, -924, -383}, '{393, -924, 383}, '{414, -1000, 0}, '{456, -383, -924},
		'{508, -707, -707}, '{551, 382, -924}, '{615, 0, -1000}, '{680, -383, 924},
		'{746, -707, 707}, '{801, 924, -383}, '{833, 707, -707}, '{878, 383, 924},
		'{913, 0, 1000}, '{940, 924, 383}, '{967, 707, 707}, '{990, 1000, 0}
	};

	typedef struct packed {
		logic signed [VEC_W-1:0] vx;
		logic signed [VEC_W-1:0] vy;
		logic [SPEED_W-1:0]      speed;
		logic [SLOT_W-1:0]       slot;
	} avg_rec_t;

	typedef struct packed {
		wva_cmd_t          cmd;
		logic [TIME_W-1:0] t_ms;
		logic [ADC_W-1:0]  adc;
		logic              fixed;
		avg_rec_t          want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [0:0] s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	wva_reg_t cfg_index = REG_DEBOUNCE;
	logic [CFG_W-1:0] cfg_data = '0;

	// predictor state and register copies
	logic [DEB_W-1:0]   deb_q = 8'd10;
	logic [SCALE_W-1:0] scale_q = 16'd1492;
	logic [TIME_W-1:0]  last_pulse_ms = '0;
	logic [CNT_W-1:0]   pulse_cnt = '0;
	int                 acc_x = 0;
	int                 acc_y = 0;
	longint             acc_speed = 0;
	int                 sec_in_window = 0;
	int                 slot_q = 0;

	avg_rec_t window_means_q [$];
	avg_rec_t got_mean, want_mean;
	dir_row_t dir_tbl [22];

	int  errors = 0;
	int  items_sent = 0;
	int  effective_items = 0;
	int  pulses_counted = 0;
	int  windows_checked = 0;
	int  regs_written = 0;
	int  cycle_cnt = 0;
	int  burst_left = 0;
	int  rdy_mode = 0;
	int  rdy_left = 0;

	wind_vector_averager #(
		.WINDOW_SECONDS(WINDOW),
		.HISTORY_SLOTS(SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	task automatic predict_averager(input wva_cmd_t cmd, input logic [TIME_W-1:0] t_ms,
		input logic [ADC_W-1:0] adc, output bit has_avg, output avg_rec_t avg);
		logic [TIME_W-1:0] since_ms;
		logic [SPEED_W-1:0] tick_speed;
		int vx, vy;
		bit found;
		has_avg = 1'b0;
		avg = '0;
		if (cmd == CMD_PULSE) begin
			since_ms = t_ms - last_pulse_ms;
			if (since_ms > deb_q) begin
				last_pulse_ms = t_ms;
				if (pulse_cnt != 16'hFFFF)
					pulse_cnt++;
				pulses_counted++;
				effective_items++;
			end
		end else begin
			vx = 0;
			vy = 0;
			found = 1'b0;
			for (int i = 0; i < 16; i++)
				if (!found && adc < COMPASS[i][0]) begin
					vx = COMPASS[i][1];
					vy = COMPASS[i][2];
					found = 1'b1;
				end
			tick_speed = pulse_cnt * scale_q;
			pulse_cnt = '0;
			acc_x += vx;
			acc_y += vy;
			acc_speed += tick_speed;
			sec_in_window++;
			effective_items++;
			if (sec_in_window == WINDOW) begin
				has_avg = 1'b1;
				avg.vx = VEC_W'(acc_x / WINDOW);
				avg.vy = VEC_W'(acc_y / WINDOW);
				avg.speed = SPEED_W'(acc_speed / WINDOW);
				avg.slot = SLOT_W'(slot_q);
				slot_q = (slot_q == SLOTS - 1) ? 0 : slot_q + 1;
				acc_x = 0;
				acc_y = 0;
				acc_speed = 0;
				sec_in_window = 0;
			end
		end
	endtask

	function automatic logic [ADC_W-1:0] pick_vane_sample();
		int k;
		k = $urandom_range(0, 15);
		if ($urandom_range(0, 2) == 0)
			return ADC_W'(COMPASS[k][0] + $urandom_range(0, 2) - 1);
		return ADC_W'($urandom_range(0, 1023));
	endfunction

	task automatic send_item(input wva_cmd_t cmd, input logic [TIME_W-1:0] t_ms,
		input logic [ADC_W-1:0] adc, input bit fixed, input avg_rec_t want);
		int gap;
		bit has_avg;
		avg_rec_t avg;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {6'd0, adc, t_ms};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		items_sent++;
		predict_averager(cmd, t_ms, adc, has_avg, avg);
		if (fixed)
			window_means_q.push_back(want);
		else if (has_avg)
			window_means_q.push_back(avg);
	endtask

	task automatic write_reg(input wva_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		regs_written++;
		if (idx == REG_DEBOUNCE)
			deb_q = val[DEB_W-1:0];
		else
			scale_q = val;
	endtask

	// block is idle once every mean has left and the pipeline has drained
	task automatic reconfigure(input logic [CFG_W-1:0] deb_val, input logic [CFG_W-1:0] scale_val);
		s_tvalid <= 1'b0;
		while (window_means_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_DEBOUNCE, deb_val);
		write_reg(REG_SPEED_SCALE, scale_val);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d means outstanding", cycle_cnt,
				window_means_q.size());
			$display("FAILURE");
			$finish;
		end
		if (m_tvalid && m_tready) begin
			got_mean.vx = m_tdata[10:0];
			got_mean.vy = m_tdata[21:11];
			got_mean.speed = m_tdata[53:22];
			got_mean.slot = m_tdata[58:54];
			if (window_means_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected mean at cycle %0d: x=%0d y=%0d speed=%0d slot=%0d",
						cycle_cnt, got_mean.vx, got_mean.vy, got_mean.speed, got_mean.slot);
			end else begin
				want_mean = window_means_q.pop_front();
				windows_checked++;
				if (got_mean.vx !== want_mean.vx || got_mean.vy !== want_mean.vy ||
						got_mean.speed !== want_mean.speed || got_mean.slot !== want_mean.slot) begin
					errors++;
					if (errors <= 10) begin
						$display("mean mismatch at cycle %0d: expected x=%0d y=%0d speed=%0d slot=%0d",
							cycle_cnt, want_mean.vx, want_mean.vy, want_mean.speed,
							want_mean.slot);
						$display("  got x=%0d y=%0d speed=%0d slot=%0d",
							got_mean.vx, got_mean.vy, got_mean.speed, got_mean.slot);
					end
				end
			end
		end
		// receiver stall pattern, chosen anew whenever its random countdown runs out
		if (rdy_left == 0) begin
			rdy_mode = $urandom_range(0, 3);
			rdy_left = $urandom_range(50, 300);
		end else
			rdy_left--;
		case (rdy_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= (cycle_cnt % 8 == 0);
			default: m_tready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	initial begin
		logic [TIME_W-1:0] clock_ms;
		logic [CFG_W-1:0] deb_w, scale_w;
		int phase_end, n;
		dir_tbl = '{
			// first pulse after reset against time zero, then debounce edges and a wrap
			'{CMD_PULSE, 32'd0, 10'd0, 1'b0, '0},
			'{CMD_PULSE, 32'd10, 10'd1023, 1'b0, '0},
			'{CMD_PULSE, 32'd11, 10'd0, 1'b0, '0},
			'{CMD_PULSE, 32'd21, 10'd0, 1'b0, '0},
			'{CMD_PULSE, 32'd22, 10'd0, 1'b0, '0},
			'{CMD_PULSE, 32'd5, 10'd0, 1'b0, '0},
			'{CMD_TICK, 32'hFFFF_FFFF, 10'd0, 1'b0, '0},
			'{CMD_TICK, 32'd0, 10'd379, 1'b0, '0},
			'{CMD_TICK, 32'd0, 10'd380, 1'b0, '0},
			'{CMD_TICK, 32'd0, 10'd989, 1'b0, '0},
			'{CMD_TICK, 32'd0, 10'd990, 1'b0, '0},
			// calm window with error direction throughout
			'{CMD_TICK, 32'd0, 10'd1023, 1'b0, '0},
			'{CMD_TICK, 32'd0, 10'd1023, 1'b0, '0},
			'{CMD_TICK, 32'd0, 10'd1023, 1'b0, '0},
			'{CMD_TICK, 32'd0, 10'd1023, 1'b0, '0},
			'{CMD_TICK, 32'd0, 10'd1023, 1'b1, '{11'sd0, 11'sd0, 32'd0, 5'd1}},
			'{CMD_PULSE, 32'hFFFF_FFFF, 10'h2AA, 1'b0, '0},
			'{CMD_TICK, 32'h5555_5555, 10'd912, 1'b0, '0},
			'{CMD_TICK, 32'hAAAA_AAAA, 10'd912, 1'b0, '0},
			'{CMD_TICK, 32'd0, 10'd912, 1'b0, '0},
			'{CMD_TICK, 32'd0, 10'd912, 1'b0, '0},
			'{CMD_TICK, 32'd0, 10'd912, 1'b0, '0}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tbl[r])
			send_item(dir_tbl[r].cmd, dir_tbl[r].t_ms, dir_tbl[r].adc, dir_tbl[r].fixed,
				dir_tbl[r].want);

		clock_ms = $urandom;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					deb_w = 16'h0000;
					scale_w = 16'hFFFF;
				end
				1: begin
					deb_w = {8'($urandom), 8'hFF};
					scale_w = 16'h0000;
				end
				2: begin
					deb_w = 16'($urandom);
					scale_w = 16'($urandom);
				end
				default: begin
					deb_w = 16'($urandom_range(0, 20));
					scale_w = 16'($urandom);
				end
			endcase
			reconfigure(deb_w, scale_w);
			phase_end = effective_items + PHASE_ITEMS;
			while (effective_items < phase_end) begin
				if ($urandom_range(0, 15) == 0)
					clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
				repeat (n) begin
					if ($urandom_range(0, 9) == 0)
						send_item(CMD_PULSE, $urandom, pick_vane_sample(), 1'b0, '0);
					else begin
						clock_ms += $urandom_range(0, 2 * deb_q + 2);
						send_item(CMD_PULSE, clock_ms, 10'($urandom), 1'b0, '0);
					end
				end
				// now and then a second passes without its tick
				if ($urandom_range(0, 19) != 0)
					send_item(CMD_TICK, $urandom, pick_vane_sample(), 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (window_means_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d transactions (%0d effective, %0d pulses counted)",
			items_sent, effective_items, pulses_counted);
		$display("%0d window means checked, %0d register writes, %0d mismatches",
			windows_checked, regs_written, errors);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
